// ===== rtl/core/okm_pkg.sv =====
package okm_pkg;

	localparam int NUM_CENTROIDS_DEF = 8;
	localparam int VECTOR_LENGTH_DEF = 16;

	// Operation codes of an input word.
	localparam logic [1:0] OP_TRAIN     = 2'd0;
	localparam logic [1:0] OP_CLASSIFY  = 2'd1;
	localparam logic [1:0] OP_SUMMARIZE = 2'd2;
	localparam logic [1:0] OP_IGNORED   = 2'd3;

	// Kind codes of a result word.
	localparam logic [1:0] KIND_LOADED     = 2'd0;
	localparam logic [1:0] KIND_TRAINED    = 2'd1;
	localparam logic [1:0] KIND_CLASSIFIED = 2'd2;
	localparam logic [1:0] KIND_SUMMARIZED = 2'd3;

	localparam logic signed [15:0] ONE_Q88 = 16'sd256;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] sample;
		logic               last;
	} okm_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  nearest_index;
		logic [35:0] min_distance;
	} okm_out_t;

	// Head of the command queue as seen by the back end.
	typedef struct packed {
		logic    valid;
		okm_in_t item;
	} okm_queue_t;

endpackage

// ===== rtl/core/okm_front.sv =====
module okm_front import okm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  okm_in_t    cmd,
	input  logic       pop,
	output okm_queue_t head
);

	okm_in_t    slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       take;

	// Ignored operations never enter the queue.
	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy && (cmd.operation != OP_IGNORED);
	assign take = pop && (cnt_q != 2'd0);

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (take) rd_q <= !rd_q;
			if (push && !take) cnt_q <= cnt_q + 2'd1;
			else if (take && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= cmd;
	end

endmodule

// ===== rtl/core/okm_div.sv =====
module okm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] dividend,
	input  logic [15:0]        divisor,
	output logic               done,
	output logic signed [15:0] quotient
);

	logic [32:0] mag_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic        neg_q;
	logic [5:0]  step_q;
	logic        run_q;
	logic [16:0] trial;
	logic        qbit;
	logic [16:0] rem_next;

	// One quotient bit per cycle, restoring, on the magnitude.
	assign trial    = {rem_q, mag_q[32]};
	assign qbit     = (trial >= {1'b0, div_q});
	assign rem_next = qbit ? (trial - {1'b0, div_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'd32) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[32];
			mag_q <= dividend[32] ? (33'd0 - dividend) : dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			mag_q <= {mag_q[31:0], qbit};
			rem_q <= rem_next[15:0];
			if (step_q == 6'd32) begin
				// Final bit lands here; clamp to the 16-bit signed range.
				if (neg_q) begin
					if ({mag_q[31:0], qbit} > 33'd32768) quotient <= 16'sh8000;
					else quotient <= 16'(16'd0 - mag_q[14:0] * 16'd2 - {15'd0, qbit});
				end else begin
					if ({mag_q[31:0], qbit} > 33'd32767) quotient <= 16'sh7FFF;
					else quotient <= {mag_q[14:0], qbit};
				end
			end
		end
	end

endmodule

// ===== rtl/core/okm_back.sv =====
module okm_back import okm_pkg::*; #(
	parameter int NUM_CENTROIDS = NUM_CENTROIDS_DEF,
	parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  okm_queue_t head,
	output logic       pop,
	output okm_out_t   result,
	output logic       done
);

	localparam int DEPTH = NUM_CENTROIDS * VECTOR_LENGTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(NUM_CENTROIDS);
	localparam int LW    = $clog2(NUM_CENTROIDS + 1);
	localparam int JW    = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
	localparam int PW    = $clog2(VECTOR_LENGTH + 1);
	localparam logic [36:0] RUN_MAX = '1;

	typedef enum logic [3:0] {
		S_IDLE, S_D_RD, S_D_MUL, S_D_ACC, S_LAST, S_L_RD, S_L_WR, S_MIN,
		S_A_RD, S_A_WR, S_FIN, S_SUM_C, S_S_RD, S_S_DIV, S_S_WAIT, S_SUM_END
	} state_t;

	state_t             state_q;
	okm_in_t            item_q;
	logic [PW-1:0]      pos_q;
	logic [PW-1:0]      j_q;
	logic [CW-1:0]      c_q;
	logic [CW-1:0]      best_q;
	logic [36:0]        dmin_q;
	logic [36:0]        run_q [NUM_CENTROIDS];
	logic [15:0]        cnt_q [NUM_CENTROIDS];
	logic [LW-1:0]      loaded_q;
	logic [JW-1:0]      slot_mod_q;
	logic [31:0]        prod_q;

	logic signed [15:0] cent_mem [DEPTH];
	logic [32:0]        sum_mem [DEPTH];
	logic [15:0]        vbuf_mem [VECTOR_LENGTH];
	logic signed [15:0] cent_rd_q;
	logic [32:0]        sum_rd_q;
	logic [15:0]        vbuf_rd_q;

	logic [AW-1:0]      cent_raddr, cent_waddr, sum_raddr, sum_waddr;
	logic               cent_we, sum_we, vbuf_we;
	logic signed [15:0] cent_wdata;
	logic [32:0]        sum_wdata;
	logic [JW-1:0]      vbuf_raddr, vbuf_waddr;

	logic signed [16:0] diff;
	logic signed [16:0] delta;
	logic signed [33:0] sq;
	logic [37:0]        racc;
	logic [33:0]        sacc;
	logic [32:0]        sbase;
	logic [15:0]        vadd;
	logic               div_start, div_done;
	logic signed [15:0] div_quot;

	assign pop = (state_q == S_IDLE);

	assign diff  = {cent_rd_q[15], cent_rd_q};
	assign delta = $signed({item_q.sample[15], item_q.sample}) - diff;
	assign sq    = delta * delta;
	assign racc  = {1'b0, run_q[c_q]} + {6'd0, prod_q};
	// An accumulator row is zero while its centroid has no members. The whole
	// row is rewritten on a training pass, so stale entries never survive.
	assign sbase = (cnt_q[best_q] == 16'd0) ? 33'd0 : sum_rd_q;
	// Elements past the end of a short vector add nothing.
	assign vadd  = (j_q < pos_q) ? vbuf_rd_q : 16'd0;
	assign sacc  = {sbase[32], sbase} + {{18{vadd[15]}}, vadd};

	okm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_rd_q),
		.divisor  (cnt_q[c_q]),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign div_start = (state_q == S_S_DIV);

	always_comb begin
		cent_raddr = AW'(c_q) * AW'(VECTOR_LENGTH) + AW'(pos_q);
		cent_we    = 1'b0;
		cent_waddr = AW'(c_q) * AW'(VECTOR_LENGTH) + AW'(j_q);
		cent_wdata = div_quot;
		sum_raddr  = AW'(c_q) * AW'(VECTOR_LENGTH) + AW'(j_q);
		sum_we     = 1'b0;
		sum_waddr  = AW'(best_q) * AW'(VECTOR_LENGTH) + AW'(j_q);
		sum_wdata  = sacc[32:0];
		vbuf_we    = 1'b0;
		vbuf_waddr = pos_q[JW-1:0];
		vbuf_raddr = j_q[JW-1:0];
		unique case (state_q)
			S_IDLE: begin
				vbuf_we = head.valid && (head.item.operation != OP_SUMMARIZE)
				       && (pos_q < PW'(VECTOR_LENGTH));
			end
			S_L_WR: begin
				cent_we    = 1'b1;
				cent_waddr = AW'(loaded_q[CW-1:0]) * AW'(VECTOR_LENGTH) + AW'(j_q);
				if (j_q == PW'(slot_mod_q)) cent_wdata = ONE_Q88;
				else if (j_q < pos_q) cent_wdata = vbuf_rd_q;
				else cent_wdata = 16'sd0;
			end
			S_A_RD: sum_raddr = AW'(best_q) * AW'(VECTOR_LENGTH) + AW'(j_q);
			S_A_WR: begin
				sum_we = 1'b1;
				if (sacc[33:32] == 2'b01) sum_wdata = 33'h0_FFFF_FFFF;
				else if (sacc[33:32] == 2'b10) sum_wdata = 33'h1_0000_0000;
			end
			S_S_WAIT: cent_we = div_done;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cent_we) cent_mem[cent_waddr] <= cent_wdata;
		cent_rd_q <= cent_mem[cent_raddr];
		if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
		sum_rd_q <= sum_mem[sum_raddr];
		if (vbuf_we) vbuf_mem[vbuf_waddr] <= head.item.sample;
		vbuf_rd_q <= vbuf_mem[vbuf_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pos_q      <= '0;
			loaded_q   <= '0;
			slot_mod_q <= '0;
			done       <= 1'b0;
			for (int i = 0; i < NUM_CENTROIDS; i++) begin
				run_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (head.valid) begin
					item_q <= head.item;
					c_q    <= '0;
					if (head.item.operation == OP_SUMMARIZE) state_q <= S_SUM_C;
					else if (pos_q < PW'(VECTOR_LENGTH)) state_q <= S_D_RD;
					else state_q <= S_LAST;
				end
				S_D_RD:  state_q <= S_D_MUL;
				S_D_MUL: begin
					prod_q  <= sq[31:0];
					state_q <= S_D_ACC;
				end
				S_D_ACC: begin
					run_q[c_q] <= racc[37] ? RUN_MAX : racc[36:0];
					if (c_q == CW'(NUM_CENTROIDS - 1)) begin
						pos_q   <= pos_q + PW'(1);
						state_q <= S_LAST;
					end else begin
						c_q     <= c_q + CW'(1);
						state_q <= S_D_RD;
					end
				end
				S_LAST: begin
					j_q    <= '0;
					best_q <= '0;
					dmin_q <= run_q[0];
					c_q    <= CW'(1);
					if (!item_q.last) state_q <= S_IDLE;
					else if (item_q.operation == OP_TRAIN
					         && loaded_q < LW'(NUM_CENTROIDS)) state_q <= S_L_RD;
					else state_q <= S_MIN;
				end
				S_L_RD: state_q <= S_L_WR;
				S_L_WR: begin
					if (j_q == PW'(VECTOR_LENGTH - 1)) begin
						result  <= '{KIND_LOADED, 6'(loaded_q), 36'd0};
						done    <= 1'b1;
						loaded_q   <= loaded_q + LW'(1);
						slot_mod_q <= (slot_mod_q == JW'(VECTOR_LENGTH - 1))
						              ? '0 : slot_mod_q + JW'(1);
						pos_q   <= '0;
						for (int i = 0; i < NUM_CENTROIDS; i++) run_q[i] <= '0;
						state_q <= S_IDLE;
					end else begin
						j_q     <= j_q + PW'(1);
						state_q <= S_L_RD;
					end
				end
				S_MIN: begin
					if (run_q[c_q] < dmin_q) begin
						dmin_q <= run_q[c_q];
						best_q <= c_q;
					end
					if (c_q == CW'(NUM_CENTROIDS - 1)) begin
						if (item_q.operation == OP_TRAIN && pos_q != '0) state_q <= S_A_RD;
						else state_q <= S_FIN;
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
				S_A_RD: state_q <= S_A_WR;
				S_A_WR: begin
					if (j_q == PW'(VECTOR_LENGTH - 1)) state_q <= S_FIN;
					else begin
						j_q     <= j_q + PW'(1);
						state_q <= S_A_RD;
					end
				end
				S_FIN: begin
					if (item_q.operation == OP_TRAIN && cnt_q[best_q] != 16'hFFFF)
						cnt_q[best_q] <= cnt_q[best_q] + 16'd1;
					result.kind          <= (item_q.operation == OP_TRAIN)
					                        ? KIND_TRAINED : KIND_CLASSIFIED;
					result.nearest_index <= 6'(best_q);
					result.min_distance  <= dmin_q[36] ? '1 : dmin_q[35:0];
					done    <= 1'b1;
					pos_q   <= '0;
					for (int i = 0; i < NUM_CENTROIDS; i++) run_q[i] <= '0;
					state_q <= S_IDLE;
				end
				S_SUM_C: begin
					j_q <= '0;
					if (cnt_q[c_q] != 16'd0) state_q <= S_S_RD;
					else if (c_q == CW'(NUM_CENTROIDS - 1)) state_q <= S_SUM_END;
					else c_q <= c_q + CW'(1);
				end
				S_S_RD:  state_q <= S_S_DIV;
				S_S_DIV: state_q <= S_S_WAIT;
				S_S_WAIT: if (div_done) begin
					if (j_q != PW'(VECTOR_LENGTH - 1)) begin
						j_q     <= j_q + PW'(1);
						state_q <= S_S_RD;
					end else if (c_q == CW'(NUM_CENTROIDS - 1)) begin
						state_q <= S_SUM_END;
					end else begin
						c_q     <= c_q + CW'(1);
						state_q <= S_SUM_C;
					end
				end
				S_SUM_END: begin
					for (int i = 0; i < NUM_CENTROIDS; i++) begin
						cnt_q[i] <= '0;
						run_q[i] <= '0;
					end
					pos_q   <= '0;
					result  <= '{KIND_SUMMARIZED, 6'd0, 36'd0};
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/online_kmeans_assign_accumulate.sv =====
// K-means engine that takes one vector element per command word and returns at most one
// result word per command. Results appear on result for exactly one cycle with done high
// and cannot be held off, so the receiver must take every word as it comes. A two-entry
// command queue lets start be accepted whenever busy is low, while the sequencer behind it
// works on one word at a time. An element word costs one centroid memory read, square and
// accumulate per centroid. A last word loads the next centroid while the first centroids
// are loaded, and otherwise runs the minimum search over all centroids, plus a rewrite of
// the whole accumulator row when training. Summarize divides every element of every
// centroid with members in the bit-serial divider. Accumulator rows read as zero while
// their centroid has no members, so no clearing pass is needed after reset.
module online_kmeans_assign_accumulate import okm_pkg::*; #(
	parameter int NUM_CENTROIDS = NUM_CENTROIDS_DEF,
	parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  okm_in_t  cmd,
	output okm_out_t result,
	output logic     done
);

	// Queue head and the pop that the sequencer issues when it is free.
	okm_queue_t head;
	logic       pop;

	okm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.pop    (pop),
		.head   (head)
	);

	okm_back #(
		.NUM_CENTROIDS (NUM_CENTROIDS),
		.VECTOR_LENGTH (VECTOR_LENGTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result),
		.done   (done)
	);

endmodule
